// ===== sv/rem_pkg.sv =====
// Shared types and constants for the reachable edge matrix builder.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rem_pkg;

  localparam int ROOM_W      = 6;
  localparam int ROW_W       = 64;
  localparam int CNT_W       = 7;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 136;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (ROOM_W + 2 * ROW_W);

  localparam logic [CNT_W-1:0]  RST_ROOM_COUNT = 7'd64;
  localparam logic [ROOM_W-1:0] RST_START_ROOM = 6'd0;
  localparam logic [ROOM_W-1:0] RST_END_ROOM   = 6'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LINK  = 2'd0,
    KIND_WALK  = 2'd1,
    KIND_CLEAR = 2'd2
  } rem_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOM_COUNT = 2'd0,
    CFG_START_ROOM = 2'd1,
    CFG_END_ROOM   = 2'd2
  } rem_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_EMIT_RD,
    ST_EMIT_LD
  } rem_state_t;

  // controller -> datapath
  typedef struct packed {
    logic link_wr;
    logic clear_all;
    logic walk_init;
    logic ptr_clr;
    logic sweep_step;
    logic emit_rd;
    logic emit_load;
  } rem_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pend_empty;
    logic out_free;
    logic emit_last;
  } rem_stat_t;

endpackage

// ===== sv/rem_ctrl.sv =====
// Controller FSM: accepts items, runs the reachability sweep, paces row emission.
// Depends on rem_pkg.
`timescale 1ns / 1ps

module rem_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rem_pkg::KIND_W-1:0]    in_tuser,
  input  rem_pkg::rem_stat_t            stat,
  output rem_pkg::rem_cmd_t             cmd
);

  rem_pkg::rem_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rem_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      rem_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_tuser)
            rem_pkg::KIND_LINK:  cmd.link_wr = 1'b1;
            rem_pkg::KIND_CLEAR: cmd.clear_all = 1'b1;
            rem_pkg::KIND_WALK: begin
              cmd.walk_init = 1'b1;
              cmd.ptr_clr   = 1'b1;
              state_nxt     = rem_pkg::ST_SWEEP;
            end
            default: ;
          endcase
        end
      end
      rem_pkg::ST_SWEEP: begin
        // keep scanning rows until no reached room is left unexpanded
        if (stat.pend_empty) begin
          cmd.ptr_clr = 1'b1;
          state_nxt   = rem_pkg::ST_EMIT_RD;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      rem_pkg::ST_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = rem_pkg::ST_EMIT_LD;
      end
      rem_pkg::ST_EMIT_LD: begin
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          state_nxt     = stat.emit_last ? rem_pkg::ST_IDLE : rem_pkg::ST_EMIT_RD;
        end
      end
      default: state_nxt = rem_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== sv/rem_dp.sv =====
// Datapath: config registers, link memory with row valid bits, reached and
// pending sets, scan pointer and output register. Depends on rem_pkg.
`timescale 1ns / 1ps

module rem_dp #(
  parameter int MAX_ROOMS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rem_pkg::rem_cmd_t                   cmd,
  output rem_pkg::rem_stat_t                  stat,
  input  logic                                cfg_valid,
  input  logic [rem_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rem_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [rem_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rem_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);

  localparam int AW  = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int CW  = rem_pkg::CNT_W;
  localparam int RMW = rem_pkg::ROOM_W;
  localparam int RW  = rem_pkg::ROW_W;
  localparam logic [CW-1:0] MAX_M1 = CW'(MAX_ROOMS - 1);

  // configuration
  logic [CW-1:0]  room_count_r;
  logic [RMW-1:0] start_room_r;
  logic [RMW-1:0] end_room_r;

  // link store
  logic [MAX_ROOMS-1:0] link_mem [MAX_ROOMS];
  logic [MAX_ROOMS-1:0] row_vld_r;
  logic [MAX_ROOMS-1:0] rd_row_r;
  logic                 rd_vld_r;
  logic [AW-1:0]        rd_idx_r;

  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic                 s1_vld_r;
  logic [MAX_ROOMS-1:0] reached_r, reached_nxt;
  logic [MAX_ROOMS-1:0] pending_r, pending_nxt;

  logic                 out_vld_r;
  logic [RMW-1:0]       out_idx_r;
  logic [RW-1:0]        out_work_r;
  logic [RW-1:0]        out_full_r;
  logic                 out_last_r;

  logic [CW-1:0]        n_m1;
  logic [AW-1:0]        last_idx;
  logic [MAX_ROOMS-1:0] mask;
  logic [RMW-1:0]       from_room, to_room;
  logic [AW-1:0]        from_idx, to_idx, start_idx;
  logic                 link_ok;
  logic [MAX_ROOMS-1:0] wr_bits, wr_mask;
  logic                 rd_en;
  logic [MAX_ROOMS-1:0] eff_row, new_bits, rd_hot, full_row;
  logic [RW-1:0]        full_ext, work_ext;

  // rooms in use, minus one, clamped to 1..MAX_ROOMS
  always_comb begin
    if (room_count_r == '0) begin
      n_m1 = '0;
    end else if (room_count_r > MAX_M1) begin
      n_m1 = MAX_M1;
    end else begin
      n_m1 = room_count_r - 1'b1;
    end
    for (int j = 0; j < MAX_ROOMS; j++) begin
      mask[j] = (CW'(j) <= n_m1);
    end
  end

  assign last_idx  = n_m1[AW-1:0];
  assign from_room = in_tdata[RMW-1:0];
  assign to_room   = in_tdata[2*RMW-1:RMW];
  assign from_idx  = from_room[AW-1:0];
  assign to_idx    = to_room[AW-1:0];
  assign start_idx = start_room_r[AW-1:0];
  assign link_ok   = cmd.link_wr && (CW'(from_room) <= n_m1) && (CW'(to_room) <= n_m1);
  assign rd_en     = cmd.sweep_step | cmd.emit_rd;

  // a row not yet valid is written whole so stale contents vanish
  always_comb begin
    wr_bits         = '0;
    wr_bits[to_idx] = 1'b1;
    wr_mask         = row_vld_r[from_idx] ? wr_bits : '1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_count_r <= rem_pkg::RST_ROOM_COUNT;
      start_room_r <= rem_pkg::RST_START_ROOM;
      end_room_r   <= rem_pkg::RST_END_ROOM;
    end else if (cfg_valid) begin
      case (cfg_index)
        rem_pkg::CFG_ROOM_COUNT: room_count_r <= cfg_data;
        rem_pkg::CFG_START_ROOM: start_room_r <= cfg_data[RMW-1:0];
        rem_pkg::CFG_END_ROOM:   end_room_r   <= cfg_data[RMW-1:0];
        default: ;
      endcase
    end
  end

  // memory: bit-enable write port, one registered read port
  always_ff @(posedge clk) begin
    if (link_ok) begin
      for (int j = 0; j < MAX_ROOMS; j++) begin
        if (wr_mask[j]) begin
          link_mem[from_idx][j] <= wr_bits[j];
        end
      end
    end
    if (rd_en) begin
      rd_row_r <= link_mem[ptr_r];
      rd_vld_r <= row_vld_r[ptr_r];
      rd_idx_r <= ptr_r;
    end
  end

  always_comb begin
    eff_row          = rd_vld_r ? (rd_row_r & mask) : '0;
    new_bits         = eff_row & ~reached_r;
    rd_hot           = '0;
    rd_hot[rd_idx_r] = 1'b1;

    reached_nxt = reached_r;
    pending_nxt = pending_r;
    if (cmd.walk_init) begin
      reached_nxt = '0;
      pending_nxt = '0;
      if (CW'(start_room_r) <= n_m1) begin
        reached_nxt[start_idx] = 1'b1;
        pending_nxt[start_idx] = 1'b1;
      end
    end else if (s1_vld_r && pending_r[rd_idx_r]) begin
      // expand one pending room; pending stays a subset of reached
      reached_nxt = reached_r | new_bits;
      pending_nxt = (pending_r & ~rd_hot) | new_bits;
    end

    if (cmd.ptr_clr) begin
      ptr_nxt = '0;
    end else if (rd_en) begin
      ptr_nxt = (ptr_r == last_idx) ? '0 : ptr_r + 1'b1;
    end else begin
      ptr_nxt = ptr_r;
    end

    full_row = reached_r[rd_idx_r] ? eff_row : '0;
    full_ext = RW'(full_row);
    work_ext = (RMW'(rd_idx_r) == end_room_r) ? '0 : full_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      reached_r <= '0;
      pending_r <= '0;
      ptr_r     <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.clear_all) begin
        row_vld_r <= '0;
      end else if (link_ok) begin
        row_vld_r[from_idx] <= 1'b1;
      end
      reached_r <= reached_nxt;
      pending_r <= pending_nxt;
      ptr_r     <= ptr_nxt;
      s1_vld_r  <= cmd.sweep_step;
      if (cmd.emit_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_idx_r  <= RMW'(rd_idx_r);
      out_work_r <= work_ext;
      out_full_r <= full_ext;
      out_last_r <= (rd_idx_r == last_idx);
    end
  end

  assign stat.pend_empty = (pending_r == '0);
  assign stat.out_free   = !out_vld_r || out_tready;
  assign stat.emit_last  = (rd_idx_r == last_idx);

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{rem_pkg::OUT_PAD_W{1'b0}}, out_full_r, out_work_r, out_idx_r};

endmodule

// ===== sv/reachable_edge_matrix_builder.sv =====
// Top level of the reachable edge matrix builder: controller plus datapath.
// Depends on rem_pkg, rem_ctrl and rem_dp.
//
//   channel | dir | handshake              | contents
//   cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//   in      | in  | in_tvalid / in_tready  | tuser kind, tdata from/to room
//   out     | out | out_tvalid / out_tready| tdata row index and rows, tlast
//
// Link add, clear and unused kinds are taken back to back while idle.
// A walk starts the sweep, which reads one link row per cycle through the
// single memory read port until no reached room is left to expand; then
// each row is emitted through a read state and a load state.
// Output stalls hold the emitter; a waiting last row does not block new items.
// Reset clears the row valid bits at once; no clearing pass is needed.
`timescale 1ns / 1ps

module reachable_edge_matrix_builder #(
  parameter int MAX_ROOMS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rem_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rem_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rem_pkg::IN_TDATA_W-1:0]      in_tdata,  // [5:0] from_room, [11:6] to_room
  input  logic [rem_pkg::KIND_W-1:0]          in_tuser,  // [1:0] kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rem_pkg::OUT_TDATA_W-1:0]     out_tdata, // [5:0] row_index, [69:6] work_row,
                                                         // [133:70] full_row
  output logic                                out_tlast  // last
);

  rem_pkg::rem_cmd_t  cmd;
  rem_pkg::rem_stat_t stat;

  assign cfg_ready = 1'b1;

  rem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  rem_dp #(
    .MAX_ROOMS (MAX_ROOMS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== sv/rem_checker.sv =====
// Port-level checks for the reachable edge matrix builder, bound to the top.
// Depends on rem_pkg and reachable_edge_matrix_builder.
`timescale 1ns / 1ps

module rem_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic [rem_pkg::KIND_W-1:0]          in_tuser,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [rem_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input logic                                out_tlast
);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result item changed while stalled");

  // a walk item closes the input side
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == rem_pkg::KIND_WALK) |=> !in_tready)
    else $error("input still open after walk item");

  // non-walk items keep the input open
  a_link_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != rem_pkg::KIND_WALK) |=> in_tready)
    else $error("input closed after non-walk item");

  // rows appear only while a walk is running
  a_row_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("row emitted outside a walk");

endmodule

bind reachable_edge_matrix_builder rem_checker u_rem_checker (.*);
